/* sv/bos_pkg.sv */
package bos_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [2:0] {
    KIND_PUSH = 3'd0,
    KIND_DUMP = 3'd1,
    KIND_PEEK = 3'd2,
    KIND_POP  = 3'd3,
    KIND_SWAP = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam int MIN_FOR_SWAP = 2;

  // Input word
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] push_value;
  } cmd_word_t;

  // Output word
  typedef struct packed {
    logic signed [31:0] value;
    status_t            status;
    logic               last;
  } res_word_t;

  // Read address select
  typedef enum logic [1:0] {
    RD_TOP    = 2'd0,
    RD_SECOND = 2'd1,
    RD_PTR    = 2'd2
  } rd_sel_t;

  // Write address and data select
  typedef enum logic [1:0] {
    WR_PUSH   = 2'd0,
    WR_TOP    = 2'd1,
    WR_SECOND = 2'd2
  } wr_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    cnt_inc;
    logic    cnt_dec;
    logic    ram_we;
    wr_sel_t wr_sel;
    logic    ram_re;
    rd_sel_t rd_sel;
    logic    ptr_load;
    logic    ptr_dec;
    logic    tmp_load;
    logic    out_load;
    logic    out_from_ram;
    status_t out_status;
    logic    out_last;
  } bos_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic count_short;
    logic count_full;
    logic ptr_zero;
    logic out_free;
  } bos_sts_t;

endpackage

/* sv/bos_ram.sv */
module bos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/bos_datapath.sv */
module bos_datapath
  import bos_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  bos_ctl_t           ctl,
  input  logic signed [31:0] push_value,
  input  logic               res_stall,
  output bos_sts_t           sts,
  output logic               res_valid,
  output res_word_t          res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] count_m2;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_m1;
  logic [31:0]   tmp;
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;

  assign count_m1 = count - CW'(1);
  assign count_m2 = count - CW'(2);
  assign ptr_m1   = ptr - AW'(1);

  // Status toward the controller
  assign sts.count_zero  = (count == '0);
  assign sts.count_short = (count < CW'(MIN_FOR_SWAP));
  assign sts.count_full  = (count >= CW'(STACK_DEPTH));
  assign sts.ptr_zero    = (ptr == '0);
  assign sts.out_free    = !res_valid || !res_stall;

  // Select read address
  always_comb begin
    case (ctl.rd_sel)
      RD_TOP:    raddr = count_m1[AW-1:0];
      RD_SECOND: raddr = count_m2[AW-1:0];
      RD_PTR:    raddr = ptr_m1;
      default:   raddr = count_m1[AW-1:0];
    endcase
  end

  // Select write address and data
  always_comb begin
    case (ctl.wr_sel)
      WR_PUSH: begin
        waddr = count[AW-1:0];
        wdata = push_value;
      end
      WR_TOP: begin
        waddr = count_m1[AW-1:0];
        wdata = rdata;
      end
      WR_SECOND: begin
        waddr = count_m2[AW-1:0];
        wdata = tmp;
      end
      default: begin
        waddr = count[AW-1:0];
        wdata = push_value;
      end
    endcase
  end

  bos_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctl.ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + CW'(1);
    end else if (ctl.cnt_dec) begin
      count <= count_m1;
    end
  end

  // Dump pointer and swap holding register
  always_ff @(posedge clk) begin
    if (ctl.ptr_load) begin
      ptr <= count_m1[AW-1:0];
    end else if (ctl.ptr_dec) begin
      ptr <= ptr_m1;
    end
    if (ctl.tmp_load) begin
      tmp <= rdata;
    end
  end

  // Output register: load a new word or drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res.value  <= ctl.out_from_ram ? rdata : 32'sd0;
      res.status <= ctl.out_status;
      res.last   <= ctl.out_last;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("element count above depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_inc |-> (count < CW'(STACK_DEPTH)))
    else $error("push on full stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.cnt_dec |-> (count != '0))
    else $error("pop on empty stack");
`endif

endmodule

/* sv/bos_ctrl.sv */
module bos_ctrl
  import bos_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  input  kind_t    kind,
  input  bos_sts_t sts,
  output logic     cmd_stall,
  output bos_ctl_t ctl
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PEEK = 6'b000010,
    S_DUMP = 6'b000100,
    S_SWA  = 6'b001000,
    S_SWB  = 6'b010000,
    S_SWC  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign cmd_stall = !((state == S_IDLE) && sts.out_free);
  assign accept    = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode operation and sequence multi-cycle work
  always_comb begin
    ctl        = '0;
    ctl.out_status = ST_OK;
    ctl.wr_sel = WR_PUSH;
    ctl.rd_sel = RD_TOP;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.out_last = 1'b1;
          case (kind)
            KIND_PUSH: begin
              ctl.out_load = 1'b1;
              if (sts.count_full) begin
                ctl.out_status = ST_OVERFLOW;
              end else begin
                ctl.ram_we  = 1'b1;
                ctl.cnt_inc = 1'b1;
              end
            end
            KIND_POP: begin
              ctl.out_load = 1'b1;
              if (sts.count_zero) begin
                ctl.out_status = ST_EMPTY;
              end else begin
                ctl.cnt_dec = 1'b1;
              end
            end
            KIND_PEEK: begin
              if (sts.count_zero) begin
                ctl.out_load   = 1'b1;
                ctl.out_status = ST_EMPTY;
              end else begin
                ctl.ram_re = 1'b1;
                state_next = S_PEEK;
              end
            end
            KIND_SWAP: begin
              if (sts.count_short) begin
                ctl.out_load   = 1'b1;
                ctl.out_status = ST_SHORT;
              end else begin
                ctl.ram_re = 1'b1;
                state_next = S_SWA;
              end
            end
            KIND_DUMP: begin
              if (!sts.count_zero) begin
                ctl.ram_re   = 1'b1;
                ctl.ptr_load = 1'b1;
                state_next   = S_DUMP;
              end
            end
            default: begin
              // unused code: drop the word
            end
          endcase
        end
      end
      S_PEEK: begin
        if (sts.out_free) begin
          ctl.out_load     = 1'b1;
          ctl.out_from_ram = 1'b1;
          ctl.out_last     = 1'b1;
          state_next       = S_IDLE;
        end
      end
      S_DUMP: begin
        if (sts.out_free) begin
          ctl.out_load     = 1'b1;
          ctl.out_from_ram = 1'b1;
          ctl.out_last     = sts.ptr_zero;
          if (sts.ptr_zero) begin
            state_next = S_IDLE;
          end else begin
            ctl.ram_re  = 1'b1;
            ctl.rd_sel  = RD_PTR;
            ctl.ptr_dec = 1'b1;
          end
        end
      end
      S_SWA: begin
        // hold top, fetch the one below
        ctl.tmp_load = 1'b1;
        ctl.ram_re   = 1'b1;
        ctl.rd_sel   = RD_SECOND;
        state_next   = S_SWB;
      end
      S_SWB: begin
        ctl.ram_we = 1'b1;
        ctl.wr_sel = WR_TOP;
        state_next = S_SWC;
      end
      S_SWC: begin
        ctl.ram_we = 1'b1;
        ctl.wr_sel = WR_SECOND;
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_swap_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWC) |-> ($past(state) == S_SWB || $past(state) == S_SWC))
    else $error("swap write-back out of order");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> sts.out_free)
    else $error("output overwritten while held");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> cmd_stall)
    else $error("word accepted while busy");
`endif

endmodule

/* sv/bounded_operand_stack_unit.sv */
// Push and pop: result registered at accept; next word the cycle after, unless stalled.
// Peek: read, then S_PEEK; swap: S_SWA, S_SWB, S_SWC (single RAM read and write port).
// Dump of n elements: one result per cycle while not stalled, after the first RAM read.
// Output stall holds the result register and blocks new words until it drains.
// Reset (rst, synchronous): element count cleared, FSM idle, no result pending.
module bounded_operand_stack_unit
  import bos_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_word_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_word_t res
);

  bos_ctl_t ctl;
  bos_sts_t sts;

  bos_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .kind      (cmd.kind),
    .sts       (sts),
    .cmd_stall (cmd_stall),
    .ctl       (ctl)
  );

  bos_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .push_value (cmd.push_value),
    .res_stall  (res_stall),
    .sts        (sts),
    .res_valid  (res_valid),
    .res        (res)
  );

endmodule
